// ----- rtl/utf8_stream_decoder_macros.svh -----
// Assertion macros for the UTF-8 stream decoder.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/u8dec_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int ByteW  = 8;
    localparam int ValueW = 22;
    localparam int PointW = 21;
    localparam int LenW   = 3;
    localparam int MaxRes = 4;
    localparam int CntW   = 3;   // holds 0 to MaxRes
    localparam int OutW   = 32;  // code_value and byte_length padded to whole bytes

    localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
    localparam logic [ByteW-1:0] ContLow    = 8'h80;
    localparam logic [ByteW-1:0] ContHigh   = 8'hBF;
    localparam logic [ByteW-1:0] TwoLow     = 8'hC0;
    localparam logic [ByteW-1:0] ThreeLow   = 8'hE0;
    localparam logic [ByteW-1:0] FourLow    = 8'hF0;
    localparam logic [ByteW-1:0] BadLow     = 8'hF8;

    // One decoded result; value is the two's-complement code_value bits.
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [LenW-1:0]   len;
        logic              last;
    } res_t;

    // Negated raw byte in two's complement.
    function automatic logic [ValueW-1:0] neg_byte(input logic [ByteW-1:0] b);
        return ValueW'(0) - {{(ValueW-ByteW){1'b0}}, b};
    endfunction

endpackage

// ----- rtl/utf8_stream_decoder.sv -----
// A result goes from the result list to the output register, which drives m_axis.
// Throughput while m_axis is not stalled: one byte per cycle while each byte gives at most
// one result; a byte that flushes a broken or cut sequence gives up to four results,
// drained one per cycle from a four-entry result list; input waits until the last moves out.
// Reset (rst_n low, asynchronous): no sequence open, result list and output empty.
// UTF-8 stream decoder top level. Depends on u8dec_pkg and the macros header.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder
    import u8dec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [7:0] text_byte
    input  logic            s_axis_tlast,   // ends_text
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [OutW-1:0] m_axis_tdata,   // [21:0] code_value, [24:22] byte_length, rest 0
    output logic            m_axis_tlast    // last_of_run
);

    // Decoder state
    logic [ByteW-1:0]  lead_reg, lead_next;
    logic [1:0]        need_reg, need_next;
    logic [1:0]        gcnt_reg, gcnt_next;
    // Only two continuations are ever held: the third one always completes the sequence.
    logic [ByteW-1:0]  gb_reg [2];
    logic [ByteW-1:0]  gb_next [2];
    logic [PointW-1:0] pp_reg, pp_next;

    // Result list and output register
    res_t              pend_reg [MaxRes];
    res_t              pend_next [MaxRes];
    logic [CntW-1:0]   pend_cnt_reg, pend_cnt_next;
    res_t              out_reg;
    logic              out_valid_reg;

    logic              out_free, move, accept;
    logic [ByteW-1:0]  b;
    logic              is_cont, is_open, cont_in_seq, completes, storing, flush;
    logic              opens, single_has;
    logic [1:0]        gcnt_inc, g_eff;
    logic [CntW-1:0]   fcnt, dec_cnt;
    logic [ByteW-1:0]  fbyte [MaxRes];
    logic [PointW-1:0] pp_shift;
    logic [ValueW-1:0] single_val;
    logic [LenW-1:0]   single_len;
    res_t              dec_res [MaxRes];

    assign b = s_axis_tdata;

    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        move          = out_free && (pend_cnt_reg != '0);
        s_axis_tready = (pend_cnt_reg == '0) || ((pend_cnt_reg == CntW'(1)) && out_free);
        accept        = s_axis_tvalid && s_axis_tready;
    end

    // Decode one byte against the current state
    always_comb
    begin
        is_cont     = b inside {[ContLow:ContHigh]};
        is_open     = need_reg != 2'd0;
        cont_in_seq = is_open && is_cont;
        completes   = cont_in_seq && (({1'b0, gcnt_reg} + 3'd1) >= {1'b0, need_reg});
        storing     = cont_in_seq && !completes;
        flush       = (is_open && !is_cont) || (storing && s_axis_tlast);
        gcnt_inc    = gcnt_reg + 2'd1;
        g_eff       = storing ? gcnt_inc : gcnt_reg;
        fcnt        = flush ? (CntW'(g_eff) + CntW'(1)) : '0;
        pp_shift    = {pp_reg[PointW-7:0], b[5:0]};

        // Starter, then gathered continuations, including this byte when it was just stored
        fbyte[0] = lead_reg;
        fbyte[1] = (storing && gcnt_reg == 2'd0) ? b : gb_reg[0];
        fbyte[2] = (storing && gcnt_reg == 2'd1) ? b : gb_reg[1];
        fbyte[3] = '0;

        opens      = 1'b0;
        single_has = 1'b0;
        single_val = '0;
        single_len = LenW'(1);
        if (completes)
        begin
            single_has = 1'b1;
            single_val = ValueW'(pp_shift);
            single_len = LenW'(need_reg) + LenW'(1);
        end
        else if (!cont_in_seq)
        begin
            if (b < AsciiLimit)
            begin
                single_has = 1'b1;
                single_val = ValueW'(b);
            end
            else if (is_cont || b >= BadLow || s_axis_tlast)
            begin
                single_has = 1'b1;
                single_val = neg_byte(b);
            end
            else
            begin
                opens = 1'b1;
            end
        end

        dec_cnt = fcnt + CntW'(single_has);
        for (int i = 0; i < MaxRes; i++)
        begin
            if (CntW'(i) < fcnt)
            begin
                dec_res[i].value = neg_byte(fbyte[i]);
                dec_res[i].len   = LenW'(1);
            end
            else
            begin
                dec_res[i].value = single_val;
                dec_res[i].len   = single_len;
            end
            dec_res[i].last = (CntW'(i) + CntW'(1)) == dec_cnt;
        end

        // Next decoder state
        lead_next  = lead_reg;
        need_next  = need_reg;
        gcnt_next  = gcnt_reg;
        gb_next[0] = gb_reg[0];
        gb_next[1] = gb_reg[1];
        pp_next    = pp_reg;
        if (storing)
        begin
            gb_next[gcnt_reg[0]] = b;
            gcnt_next            = gcnt_inc;
            pp_next              = pp_shift;
        end
        else if (opens)
        begin
            lead_next = b;
            gcnt_next = 2'd0;
            if (b < ThreeLow)
            begin
                need_next = 2'd1;
                pp_next   = PointW'(b[4:0]);
            end
            else if (b < FourLow)
            begin
                need_next = 2'd2;
                pp_next   = PointW'(b[3:0]);
            end
            else
            begin
                need_next = 2'd3;
                pp_next   = PointW'(b[2:0]);
            end
        end
        else
        begin
            // Completed, flushed or single byte: close the sequence
            lead_next = '0;
            need_next = 2'd0;
            gcnt_next = 2'd0;
            pp_next   = '0;
        end
        // End of text clears everything
        if (s_axis_tlast)
        begin
            lead_next = '0;
            need_next = 2'd0;
            gcnt_next = 2'd0;
            pp_next   = '0;
        end
    end

    // Result list: drain from the front, reload on a transfer in
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        for (int i = 0; i < MaxRes; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (move)
        begin
            for (int i = 0; i < MaxRes - 1; i++)
            begin
                pend_next[i] = pend_reg[i+1];
            end
            pend_cnt_next = pend_cnt_reg - CntW'(1);
        end
        if (accept)
        begin
            for (int i = 0; i < MaxRes; i++)
            begin
                pend_next[i] = dec_res[i];
            end
            pend_cnt_next = dec_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg      <= '0;
            need_reg      <= 2'd0;
            gcnt_reg      <= 2'd0;
            pp_reg        <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lead_reg <= lead_next;
                need_reg <= need_next;
                gcnt_reg <= gcnt_next;
                pp_reg   <= pp_next;
            end
            pend_cnt_reg <= pend_cnt_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gb_reg[0] <= gb_next[0];
            gb_reg[1] <= gb_next[1];
        end
        for (int i = 0; i < MaxRes; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
        if (move)
        begin
            out_reg <= pend_reg[0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutW-ValueW-LenW){1'b0}}, out_reg.len, out_reg.value};
    assign m_axis_tlast  = out_reg.last;

    `U8D_ASSERT_NEXT(a_pend_reaches_out, pend_cnt_reg != '0, m_axis_tvalid,
        "pending result did not reach the output register")
    `U8D_ASSERT_SAME(a_open_lead_is_starter, need_reg != 2'd0,
        lead_reg >= TwoLow && lead_reg < BadLow, "open sequence without a valid starter")
    `U8D_ASSERT_SAME(a_multibyte_is_point, m_axis_tvalid && m_axis_tdata[24:22] > 3'd1,
        !m_axis_tdata[21] && m_axis_tlast, "multi-byte result is negative or not last")

endmodule

// ----- tb/utf8_stream_decoder_tb.sv -----
// Self-checking testbench for utf8_stream_decoder: a directed byte table, then random
// UTF-8 text; each result is checked against its typed row or a decoder model here.
// Depends on u8dec_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb
    import u8dec_pkg::*;
();

    typedef struct packed {
        logic [ValueW-1:0] code;
        logic [LenW-1:0]   len;
        logic              last;
    } code_point_t;

    // One text byte; typed rows carry the single result they must give.
    typedef struct packed {
        logic [ByteW-1:0]  text_byte;
        logic              ends_text;
        logic              typed;
        logic [ValueW-1:0] code;
        logic [LenW-1:0]   len;
    } text_row_t;

    typedef struct packed {
        text_row_t row;
        logic      drain;   // wait for every pending result before offering
    } text_item_t;

    localparam int DirectedRows = 25;
    localparam int RandomBytes  = 155;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OutW-1:0]   m_axis_tdata;
    logic              m_axis_tlast;

    text_row_t   directed_rows [DirectedRows];
    text_item_t  byte_stream_q [$];
    code_point_t pending_points [$];
    code_point_t decoded_run [$];

    // decoder model state
    logic [ByteW-1:0]  open_lead = '0;
    logic [1:0]        open_need = '0;
    logic [1:0]        open_got = '0;
    logic [ByteW-1:0]  open_conts [3];
    logic [PointW-1:0] open_payload = '0;

    int bytes_taken = 0;
    int error_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_pos = 0;
    logic [15:0] stall_pattern = '1;

    utf8_stream_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [ValueW-1:0] negate_byte(input logic [ByteW-1:0] b);
        return ~{{(ValueW-ByteW){1'b0}}, b} + 1'b1;
    endfunction

    task automatic add_point(input logic [ValueW-1:0] code, input logic [LenW-1:0] len);
        code_point_t point;
        point.code = code;
        point.len = len;
        point.last = 1'b0;
        if (decoded_run.size() < MaxRes)
            decoded_run.insert(decoded_run.size(), point);
    endtask

    task automatic clear_open_sequence();
        open_lead = '0;
        open_need = '0;
        open_got = '0;
        open_payload = '0;
    endtask

    // Emit the starter and every gathered continuation as negated bytes.
    task automatic flush_open_sequence();
        add_point(negate_byte(open_lead), 3'd1);
        for (int k = 0; k < int'(open_got); k++)
            add_point(negate_byte(open_conts[k]), 3'd1);
        clear_open_sequence();
    endtask

    // Advance the decoder model by one byte; results land in decoded_run.
    task automatic decode_text_byte(input logic [ByteW-1:0] b, input logic fin);
        logic is_cont;
        is_cont = (b >= ContLow) && (b <= ContHigh);
        decoded_run.delete();
        if (open_need != 0 && is_cont)
        begin
            open_payload = {open_payload[PointW-7:0], b[5:0]};
            if (int'(open_got) + 1 >= int'(open_need))
            begin
                add_point({1'b0, open_payload}, LenW'(open_need) + 3'd1);
                clear_open_sequence();
            end
            else
            begin
                open_conts[open_got] = b;
                open_got = open_got + 2'd1;
                if (fin)
                    flush_open_sequence();
            end
        end
        else
        begin
            // a broken sequence goes out first, then the byte is taken afresh
            if (open_need != 0)
                flush_open_sequence();
            if (b < AsciiLimit)
                add_point({{(ValueW-ByteW){1'b0}}, b}, 3'd1);
            else if (is_cont || b >= BadLow || fin)
                add_point(negate_byte(b), 3'd1);
            else
            begin
                open_lead = b;
                open_got = '0;
                if (b < ThreeLow)
                begin
                    open_need = 2'd1;
                    open_payload = PointW'(b - TwoLow);
                end
                else if (b < FourLow)
                begin
                    open_need = 2'd2;
                    open_payload = PointW'(b - ThreeLow);
                end
                else
                begin
                    open_need = 2'd3;
                    open_payload = PointW'(b - FourLow);
                end
            end
        end
        if (fin)
            clear_open_sequence();
        if (decoded_run.size() > 0)
            decoded_run[decoded_run.size()-1].last = 1'b1;
    endtask

    task automatic queue_text_byte(input logic [ByteW-1:0] b, input logic fin);
        text_item_t item;
        item.row = '{text_byte: b, ends_text: fin, typed: 1'b0, code: '0, len: '0};
        // pause the sender at the start of the random part and once more later on
        item.drain = (byte_stream_q.size() == DirectedRows) ||
                     (byte_stream_q.size() == DirectedRows + 100);
        byte_stream_q.insert(byte_stream_q.size(), item);
    endtask

    function automatic logic [ByteW-1:0] random_starter(input int need);
        case (need)
            1: return TwoLow | ByteW'($urandom_range(0, 31));
            2: return ThreeLow | ByteW'($urandom_range(0, 15));
            default: return FourLow | ByteW'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [ByteW-1:0] random_cont();
        return ContLow | ByteW'($urandom_range(0, 63));
    endfunction

    // Sender, input prediction and result checking share one process.
    always @(posedge clk)
    begin : stream_side
        code_point_t seen;
        code_point_t want;
        logic fired;
        if (rst_n)
        begin
            fired = s_axis_tvalid && s_axis_tready;
            if (fired)
            begin
                decode_text_byte(byte_stream_q[0].row.text_byte, byte_stream_q[0].row.ends_text);
                if (byte_stream_q[0].row.typed)
                    pending_points.insert(pending_points.size(),
                                          {byte_stream_q[0].row.code,
                                           byte_stream_q[0].row.len, 1'b1});
                else
                    foreach (decoded_run[i])
                        pending_points.insert(pending_points.size(), decoded_run[i]);
                void'(byte_stream_q.pop_front());
                bytes_taken <= bytes_taken + 1;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = '{code: m_axis_tdata[ValueW-1:0],
                         len: m_axis_tdata[ValueW+LenW-1:ValueW],
                         last: m_axis_tlast};
                if (pending_points.size() == 0)
                begin
                    $display("%0t: result with nothing pending: code_value %h byte_length %0d",
                             $time, seen.code, seen.len);
                    error_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (seen.code != want.code)
                    begin
                        $display("%0t: code_value expected %h actual %h",
                                 $time, want.code, seen.code);
                        error_count++;
                    end
                    if (seen.len != want.len)
                    begin
                        $display("%0t: byte_length expected %0d actual %0d",
                                 $time, want.len, seen.len);
                        error_count++;
                    end
                    if (seen.last != want.last)
                    begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, want.last, seen.last);
                        error_count++;
                    end
                    if (m_axis_tdata[OutW-1:ValueW+LenW] != '0)
                    begin
                        $display("%0t: tdata padding expected 0 actual %h",
                                 $time, m_axis_tdata[OutW-1:ValueW+LenW]);
                        error_count++;
                    end
                end
            end

            // hold a pending transfer; otherwise pick the next one or idle
            if (!s_axis_tvalid || fired)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (byte_stream_q.size() == 0 ||
                         (byte_stream_q[0].drain && pending_points.size() != 0))
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= byte_stream_q[0].row.text_byte;
                    s_axis_tlast <= byte_stream_q[0].row.ends_text;
                    if (burst_left != 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        if (bytes_taken >= 130 && bytes_taken < 165)
                            gap_left = 0;
                        else if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall on random 16-bit patterns, with one long hold-off and a ready window.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && bytes_taken >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 80;
                m_axis_tready <= 1'b0;
            end
            else if (bytes_taken >= 130 && bytes_taken < 165)
                m_axis_tready <= 1'b1;
            else
            begin
                if (stall_pos == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = '1;
                        1: stall_pattern = 16'($urandom);
                        2: stall_pattern = 16'($urandom) | 16'($urandom);
                        default: stall_pattern = 16'($urandom) & 16'($urandom);
                    endcase
                end
                m_axis_tready <= stall_pattern[stall_pos];
                stall_pos = (stall_pos + 1) % 16;
            end
        end
    end

    initial
    begin
        text_item_t item;
        int need;
        int conts;
        logic [ByteW-1:0] b;

        // text_byte, ends_text, typed, code_value, byte_length
        directed_rows = '{
            {8'h00, 1'b0, 1'b1, 22'h000000, 3'd1},   // ASCII low edge right after reset
            {8'h7F, 1'b1, 1'b1, 22'h00007F, 3'd1},   // ASCII high edge, ends the text
            {8'h80, 1'b0, 1'b1, 22'h3FFF80, 3'd1},   // lone continuation
            {8'hFF, 1'b0, 1'b1, 22'h3FFF01, 3'd1},   // invalid byte, top
            {8'hF8, 1'b0, 1'b1, 22'h3FFF08, 3'd1},   // invalid byte, bottom
            {8'hC0, 1'b0, 1'b0, 22'h0, 3'd0},        // overlong two-byte zero
            {8'h80, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hE2, 1'b0, 1'b0, 22'h0, 3'd0},        // three-byte sequence
            {8'h82, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hAC, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hF7, 1'b0, 1'b0, 22'h0, 3'd0},        // largest four-byte value
            {8'hBF, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hBF, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hBF, 1'b0, 1'b1, 22'h1FFFFF, 3'd4},
            {8'hF4, 1'b0, 1'b0, 22'h0, 3'd0},        // broken after two continuations
            {8'h8F, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'h8F, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hFF, 1'b0, 1'b0, 22'h0, 3'd0},        // four results from one byte
            {8'hC3, 1'b1, 1'b1, 22'h3FFF3D, 3'd1},   // starter as the last byte
            {8'hF0, 1'b0, 1'b0, 22'h0, 3'd0},        // cut by end of text
            {8'h90, 1'b1, 1'b0, 22'h0, 3'd0},
            {8'hE0, 1'b0, 1'b0, 22'h0, 3'd0},        // broken by ASCII
            {8'h41, 1'b0, 1'b0, 22'h0, 3'd0},
            {8'hDF, 1'b0, 1'b0, 22'h0, 3'd0},        // completes on the last byte
            {8'hBF, 1'b1, 1'b0, 22'h0, 3'd0}
        };
        foreach (directed_rows[i])
        begin
            item.row = directed_rows[i];
            item.drain = 1'b0;
            byte_stream_q.insert(byte_stream_q.size(), item);
        end

        while (byte_stream_q.size() < DirectedRows + RandomBytes)
        begin
            case ($urandom_range(0, 99)) inside
                [0:59]:
                begin
                    // well-formed code point
                    need = $urandom_range(0, 3);
                    if (need == 0)
                        queue_text_byte(ByteW'($urandom_range(0, 127)),
                                        $urandom_range(0, 7) == 0);
                    else
                    begin
                        queue_text_byte(random_starter(need), 1'b0);
                        for (int k = 0; k < need; k++)
                            queue_text_byte(random_cont(),
                                            k == need - 1 && $urandom_range(0, 7) == 0);
                    end
                end
                [60:74]:
                begin
                    // sequence broken by a non-continuation byte
                    need = $urandom_range(1, 3);
                    conts = $urandom_range(0, need - 1);
                    queue_text_byte(random_starter(need), 1'b0);
                    repeat (conts) queue_text_byte(random_cont(), 1'b0);
                    case ($urandom_range(0, 2))
                        0: b = ByteW'($urandom_range(0, 127));
                        1: b = random_starter($urandom_range(1, 3));
                        default: b = ByteW'($urandom_range(248, 255));
                    endcase
                    queue_text_byte(b, $urandom_range(0, 7) == 0);
                end
                [75:84]:
                begin
                    // sequence cut by the end of the text
                    need = $urandom_range(1, 3);
                    conts = $urandom_range(0, need - 1);
                    queue_text_byte(random_starter(need), conts == 0);
                    for (int k = 0; k < conts; k++)
                        queue_text_byte(random_cont(), k == conts - 1);
                end
                default:
                    queue_text_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            endcase
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_stream_q.size() != 0 || pending_points.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("[utf8_stream_decoder] OK");
        else
            $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/u8dec_pkg.sv
rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
